FILE: sv/cua_pkg.sv
// Shared types and constants for the contiguous unit allocator.
package cua_pkg;

	localparam int MAX_UNITS = 64;
	localparam int ID_BITS   = 16;
	localparam int SLOT_W    = $clog2(MAX_UNITS);
	localparam int CNT_W     = $clog2(MAX_UNITS + 1);
	localparam logic [ID_BITS-1:0] ID_MAX = '1;

	localparam int SIZE_W   = 7;
	localparam int UNITS_W  = 7;
	localparam int POLICY_W = 2;
	localparam int STATUS_W = 2;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;

	localparam logic REG_FIT_POLICY = 1'b0;
	localparam logic REG_UNITS      = 1'b1;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2,
		POL_NEXT  = 2'd3
	} policy_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_BAD_SIZE  = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_REMOVE = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH,
		S_WRITE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic               wr_en;
		logic [SLOT_W-1:0]  wr_addr;
		logic [ID_BITS-1:0] wr_data;
		logic               rd_en;
		logic [SLOT_W-1:0]  rd_addr;
	} map_req_t;

endpackage

FILE: sv/cua_slot_map.sv
// Slot owner memory with per-entry valid bits; unwritten slots read as free.
module cua_slot_map (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cua_pkg::map_req_t          req,
	output logic [cua_pkg::ID_BITS-1:0] rd_data
);

	logic [cua_pkg::ID_BITS-1:0]   mem_q [cua_pkg::MAX_UNITS];
	logic [cua_pkg::MAX_UNITS-1:0] vld_q;
	logic [cua_pkg::ID_BITS-1:0]   mem_rd_s1;
	logic                          vld_rd_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			mem_rd_s1 <= mem_q[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_rd_s1 <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				vld_rd_s1 <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = vld_rd_s1 ? mem_rd_s1 : '0;

endmodule

FILE: sv/contiguous_unit_allocator_core.sv
// Contiguous unit allocator: slot map, scan sequencer, APB registers, stream ports.
// An insert scans the slot map and then writes its run one slot at a time; next fit
// may take two scans; a remove takes one scan; rejected sizes go straight to the result.
// One request at a time: a new request is taken only once the result is loaded, and the
// scan reads one slot per cycle and the write phase writes one slot per cycle after it.
// Reset (arst_n low, asynchronous) frees every slot, clears the id counter and rover,
// and sets first fit with 64 units.
module contiguous_unit_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [cua_pkg::S_DATA_W-1:0]  s_tdata,  // request_size[6:0], owner_to_free[22:7]
	input  logic                          s_tuser,  // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cua_pkg::M_DATA_W-1:0]  m_tdata,  // status[1:0], owner_id[17:2],
	                                                // start_slot[23:18], slot_count[30:24]
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cua_pkg::ADDR_W-1:0]    paddr,
	input  logic [cua_pkg::DATA_W-1:0]    pwdata,
	output logic [cua_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	localparam int CW = cua_pkg::CNT_W;
	localparam int SW = cua_pkg::SLOT_W;
	localparam int IW = cua_pkg::ID_BITS;

	cua_pkg::state_t  state_q, state_d;
	cua_pkg::policy_t policy_q;
	cua_pkg::kind_t   kind_q;
	cua_pkg::status_t res_status_q;
	cua_pkg::map_req_t map_req;

	logic [cua_pkg::UNITS_W-1:0] units_cfg_q;
	logic [IW-1:0] last_id_q, id_q, rd_data;
	logic [SW-1:0] rover_q, rover_eff_q, idx_s1, run_start_q, pick_q;
	logic [CW-1:0] size_q, idx_q, end_q, len_q, ref_q, cnt_q;
	logic          pass_q, v_s1, hit_q, pick_ok_q;
	logic          out_valid_q;
	logic [cua_pkg::M_DATA_W-1:0] out_data_q;

	logic [CW-1:0] units_c, size_in, len_inc, rover_sum;
	logic [SW-1:0] rover_c, start_n, wr_addr_c;
	logic [IW-1:0] own_in, new_id_c;
	logic          accept, cfg_wr, issue_c, proc_c, slot_free, ranked_c, close_take;
	logic          scan_done, wr_last, rm_match, bad_size, out_load;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			cua_pkg::REG_FIT_POLICY: prdata = {{(cua_pkg::DATA_W - cua_pkg::POLICY_W){1'b0}},
				policy_q};
			cua_pkg::REG_UNITS:      prdata = {{(cua_pkg::DATA_W - cua_pkg::UNITS_W){1'b0}},
				units_cfg_q};
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= cua_pkg::POL_FIRST;
			units_cfg_q <= cua_pkg::UNITS_W'(cua_pkg::MAX_UNITS);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				cua_pkg::REG_FIT_POLICY: policy_q <= cua_pkg::policy_t'(
					pwdata[cua_pkg::POLICY_W-1:0]);
				cua_pkg::REG_UNITS:      units_cfg_q <= pwdata[cua_pkg::UNITS_W-1:0];
				default:                 ;
			endcase
		end
	end

	// Slot memory
	cua_slot_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (map_req),
		.rd_data (rd_data)
	);

	// Shared scan datapath
	assign units_c   = (CW'(units_cfg_q) > CW'(cua_pkg::MAX_UNITS)) ?
		CW'(cua_pkg::MAX_UNITS) : CW'(units_cfg_q);
	assign rover_c   = ({1'b0, rover_q} < units_c) ? rover_q : '0;
	assign new_id_c  = (last_id_q == cua_pkg::ID_MAX) ? IW'(1) : last_id_q + IW'(1);
	assign size_in   = CW'(s_tdata[cua_pkg::SIZE_W-1:0]);
	assign own_in    = s_tdata[cua_pkg::SIZE_W +: IW];
	assign accept    = s_tvalid && s_tready;
	assign bad_size  = (size_in == '0) || (size_in > units_c);

	assign issue_c   = (state_q == cua_pkg::S_SCAN) && !hit_q && (idx_q < end_q);
	assign proc_c    = (state_q == cua_pkg::S_SCAN) && v_s1 && !hit_q;
	assign slot_free = (rd_data == '0);
	assign rm_match  = (rd_data == id_q) && (id_q != '0);
	assign ranked_c  = (policy_q == cua_pkg::POL_BEST) || (policy_q == cua_pkg::POL_WORST);
	assign len_inc   = len_q + CW'(1);
	assign start_n   = (len_q == '0) ? idx_s1 : run_start_q;
	assign close_take = (len_q != '0) && (len_q >= size_q) &&
		((policy_q == cua_pkg::POL_WORST) ? (len_q >= ref_q) : (len_q <= ref_q));
	assign scan_done = (state_q == cua_pkg::S_SCAN) && !v_s1 && (hit_q || (idx_q >= end_q));
	assign wr_last   = (cnt_q + CW'(1)) == size_q;
	assign wr_addr_c = pick_q + cnt_q[SW-1:0];
	assign rover_sum = CW'(pick_q) + size_q;
	assign out_load  = (state_q == cua_pkg::S_DONE) && (!out_valid_q || m_tready);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cua_pkg::S_IDLE: begin
				if (accept) begin
					if ((cua_pkg::kind_t'(s_tuser) == cua_pkg::KIND_INSERT) && bad_size) begin
						state_d = cua_pkg::S_DONE;
					end else begin
						state_d = cua_pkg::S_SCAN;
					end
				end
			end
			cua_pkg::S_SCAN: begin
				if (scan_done) begin
					if (kind_q == cua_pkg::KIND_REMOVE) begin
						state_d = cua_pkg::S_DONE;
					end else if (hit_q) begin
						state_d = cua_pkg::S_WRITE;
					end else if ((policy_q == cua_pkg::POL_NEXT) && !pass_q &&
						(rover_eff_q != '0)) begin
						state_d = cua_pkg::S_SCAN;
					end else if (ranked_c) begin
						state_d = cua_pkg::S_FLUSH;
					end else begin
						state_d = cua_pkg::S_DONE;
					end
				end
			end
			cua_pkg::S_FLUSH: begin
				state_d = (close_take || pick_ok_q) ? cua_pkg::S_WRITE : cua_pkg::S_DONE;
			end
			cua_pkg::S_WRITE: begin
				if (wr_last) begin
					state_d = cua_pkg::S_DONE;
				end
			end
			cua_pkg::S_DONE: begin
				if (out_load) begin
					state_d = cua_pkg::S_IDLE;
				end
			end
			default: state_d = cua_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		s_tready        = (state_q == cua_pkg::S_IDLE);
		map_req.rd_en   = issue_c;
		map_req.rd_addr = idx_q[SW-1:0];
		map_req.wr_en   = 1'b0;
		map_req.wr_addr = idx_s1;
		map_req.wr_data = '0;
		unique case (state_q)
			cua_pkg::S_SCAN: begin
				map_req.wr_en = proc_c && (kind_q == cua_pkg::KIND_REMOVE) && rm_match;
			end
			cua_pkg::S_WRITE: begin
				map_req.wr_en   = 1'b1;
				map_req.wr_addr = wr_addr_c;
				map_req.wr_data = id_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cua_pkg::S_IDLE;
			last_id_q    <= '0;
			rover_q      <= '0;
			rover_eff_q  <= '0;
			v_s1         <= 1'b0;
			hit_q        <= 1'b0;
			pick_ok_q    <= 1'b0;
			pass_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			kind_q       <= cua_pkg::KIND_INSERT;
			res_status_q <= cua_pkg::ST_OK;
			id_q         <= '0;
			size_q       <= '0;
			ref_q        <= '0;
			pick_q       <= '0;
			run_start_q  <= '0;
			cnt_q        <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			end_q        <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue_c;
			if (issue_c) begin
				idx_q <= idx_q + CW'(1);
			end

			unique case (state_q)
				cua_pkg::S_IDLE: begin
					if (accept) begin
						kind_q    <= cua_pkg::kind_t'(s_tuser);
						size_q    <= size_in;
						cnt_q     <= '0;
						len_q     <= '0;
						hit_q     <= 1'b0;
						pick_ok_q <= 1'b0;
						pass_q    <= 1'b0;
						idx_q     <= ((cua_pkg::kind_t'(s_tuser) == cua_pkg::KIND_INSERT) &&
							(policy_q == cua_pkg::POL_NEXT)) ? CW'(rover_c) : '0;
						end_q     <= units_c;
						ref_q     <= (policy_q == cua_pkg::POL_WORST) ? '0 : units_c;
						if (cua_pkg::kind_t'(s_tuser) == cua_pkg::KIND_REMOVE) begin
							id_q         <= own_in;
							res_status_q <= cua_pkg::ST_NOT_FOUND;
						end else if (size_in == '0) begin
							id_q         <= '0;
							res_status_q <= cua_pkg::ST_BAD_SIZE;
						end else if (size_in > units_c) begin
							id_q         <= '0;
							res_status_q <= cua_pkg::ST_NO_SPACE;
						end else begin
							last_id_q    <= new_id_c;
							id_q         <= new_id_c;
							res_status_q <= cua_pkg::ST_NO_SPACE;
							rover_eff_q  <= rover_c;
						end
					end
				end
				cua_pkg::S_SCAN: begin
					if (proc_c) begin
						if (kind_q == cua_pkg::KIND_REMOVE) begin
							if (rm_match) begin
								cnt_q        <= cnt_q + CW'(1);
								res_status_q <= cua_pkg::ST_OK;
							end
						end else if (slot_free) begin
							run_start_q <= start_n;
							len_q       <= len_inc;
							if (!ranked_c && (len_inc >= size_q)) begin
								hit_q     <= 1'b1;
								pick_q    <= start_n;
								pick_ok_q <= 1'b1;
							end
						end else begin
							len_q <= '0;
							if (ranked_c && close_take) begin
								pick_q    <= run_start_q;
								ref_q     <= len_q;
								pick_ok_q <= 1'b1;
								if ((policy_q == cua_pkg::POL_BEST) && (len_q == size_q)) begin
									hit_q <= 1'b1;
								end
							end
						end
					end
					if (scan_done && (kind_q == cua_pkg::KIND_INSERT) && !hit_q &&
						(policy_q == cua_pkg::POL_NEXT) && !pass_q && (rover_eff_q != '0)) begin
						pass_q <= 1'b1;
						idx_q  <= '0;
						end_q  <= CW'(rover_eff_q);
						len_q  <= '0;
					end
				end
				cua_pkg::S_FLUSH: begin
					len_q <= '0;
					if (close_take) begin
						pick_q    <= run_start_q;
						ref_q     <= len_q;
						pick_ok_q <= 1'b1;
					end
				end
				cua_pkg::S_WRITE: begin
					cnt_q <= cnt_q + CW'(1);
					if (wr_last) begin
						res_status_q <= cua_pkg::ST_OK;
						if (policy_q == cua_pkg::POL_NEXT) begin
							rover_q <= (rover_sum == units_c) ? '0 : rover_sum[SW-1:0];
						end
					end
				end
				default: ;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_c) begin
			idx_s1 <= idx_q[SW-1:0];
		end
		if (out_load) begin
			out_data_q <= {1'b0, cnt_q,
				((res_status_q == cua_pkg::ST_OK) && (kind_q == cua_pkg::KIND_INSERT)) ?
					pick_q : {SW{1'b0}},
				id_q, res_status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cua_pkg::S_WRITE) |-> (cnt_q < size_q) && pick_ok_q)
		else $error("run write past requested size");

	a_run_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cua_pkg::S_WRITE) |-> ((CW + 1)'(pick_q) + (CW + 1)'(size_q)
			<= (CW + 1)'(units_c)))
		else $error("granted run exceeds managed slots");

	a_read_only_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == cua_pkg::S_SCAN))
		else $error("slot read in flight outside a scan");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		map_req.wr_en |-> (state_q == cua_pkg::S_WRITE) ||
			((state_q == cua_pkg::S_SCAN) && (kind_q == cua_pkg::KIND_REMOVE)))
		else $error("slot map written outside write or remove scan");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (state_q == cua_pkg::S_IDLE) && out_valid_q)
		else $error("result not held after completion");
`endif

endmodule
